FILE: hw/rtl/pdf_pkg.sv
// Shared types and constants for the pairwise distance-decay force unit.
`timescale 1ns / 1ps
package pdf_pkg;

  // Input transaction: one source/target pair
  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic        [15:0] infected_load;
    logic        [15:0] carcass_load;
    logic               row_end_in;
  } pdf_in_t;

  // Result transaction
  typedef struct packed {
    logic signed [47:0] force_res;
    logic               in_range;
    logic               saturated;
    logic               row_end;
  } pdf_out_t;

  // One kernel term with its cap flag
  typedef struct packed {
    logic signed [51:0] value;
    logic               capped;
  } pdf_term_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INTERCEPT   = 3'd0,
    REG_LIVE_SLOPE  = 3'd1,
    REG_CARC_SLOPE  = 3'd2,
    REG_LIVE_WEIGHT = 3'd3,
    REG_CARC_WEIGHT = 3'd4,
    REG_CUTOFF      = 3'd5
  } pdf_reg_t;

  localparam int CUTOFF_UNITS = 5;

  // Square root: root bits and iterations per stage
  localparam int SQRT_BITS      = 31;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = (SQRT_BITS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

  // Exponential
  localparam logic signed [63:0] EXP_CLAMP = 64'sd1073741824;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;
  localparam int HORNER_TERMS = 12;

  // floor(2^32 / i), used to divide by the Horner step index
  localparam logic [32:0] HORNER_RECIP [1:HORNER_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  // Term scaling
  localparam int SCALE_SHIFT = 38;
  localparam int CAP_BITS    = 50;

  // Kernel depth: exponent front, Horner chain, scale back end
  localparam int KERN_STAGES = 4 + 3 * HORNER_TERMS + 4;

  localparam logic signed [52:0] OUT_MAX = 53'sd140737488355327;
  localparam logic signed [52:0] OUT_MIN = -53'sd140737488355328;

endpackage

FILE: hw/rtl/pairwise_distance_decay_force_unit.sv
// Top level of the pairwise distance-decay force unit.
`timescale 1ns / 1ps
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+-----------
//  input    | start, busy, in_data (pdf_in_t)         | in / out
//  result   | out_valid, out_data (pdf_out_t)         | out
//  config   | psel, penable, pwrite, paddr, pwdata,   | in / out
//           | prdata, pready                          |
//
//  One pair per clock; busy never rises. Every transaction gives one result,
//  passing through 3 front stages (difference, squares, range
//  check), 16 square-root stages at up to two root bits each, 44 kernel stages
//  dominated by the 12-step Horner chain at 3 stages per step, 1 output stage.
//  rst_n is synchronous; it clears the valid line and loads register defaults.
//  The receiver cannot stall, so the pipeline advances every cycle.
module pairwise_distance_decay_force_unit #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pdf_pkg::pdf_in_t  in_data,
  output logic              out_valid,
  output pdf_pkg::pdf_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int RB       = pdf_pkg::SQRT_BITS;
  localparam int SQ       = pdf_pkg::SQRT_STAGES;
  localparam int LINE     = SQ + pdf_pkg::KERN_STAGES;
  localparam int PIPE_LAT = 3 + LINE + 1;
  localparam logic [30:0] CUTOFF_RESET = 31'(pdf_pkg::CUTOFF_UNITS << COORD_FRAC_BITS);

  typedef struct packed {
    logic [15:0] infected;
    logic [15:0] carcass;
  } load_t;

  typedef struct packed {
    logic valid;
    logic in_range;
    logic row_end;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [31:0] intercept_r, live_slope_r, carc_slope_r, live_weight_r, carc_weight_r;
  logic [30:0] cutoff_r;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intercept_r   <= '0;
      live_slope_r  <= '0;
      carc_slope_r  <= '0;
      live_weight_r <= '0;
      carc_weight_r <= '0;
      cutoff_r      <= CUTOFF_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        pdf_pkg::REG_INTERCEPT:   intercept_r   <= pwdata;
        pdf_pkg::REG_LIVE_SLOPE:  live_slope_r  <= pwdata;
        pdf_pkg::REG_CARC_SLOPE:  carc_slope_r  <= pwdata;
        pdf_pkg::REG_LIVE_WEIGHT: live_weight_r <= pwdata;
        pdf_pkg::REG_CARC_WEIGHT: carc_weight_r <= pwdata;
        pdf_pkg::REG_CUTOFF:      cutoff_r      <= pwdata[30:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pdf_pkg::REG_INTERCEPT:   prdata = intercept_r;
      pdf_pkg::REG_LIVE_SLOPE:  prdata = live_slope_r;
      pdf_pkg::REG_CARC_SLOPE:  prdata = carc_slope_r;
      pdf_pkg::REG_LIVE_WEIGHT: prdata = live_weight_r;
      pdf_pkg::REG_CARC_WEIGHT: prdata = carc_weight_r;
      pdf_pkg::REG_CUTOFF:      prdata = {1'b0, cutoff_r};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- front: differences, squares, range check ----------------
  logic              accept;
  logic signed [32:0] dx, dy;
  logic [31:0]       adx_nxt, ady_nxt;

  assign accept  = start && !busy;
  assign dx      = $signed({in_data.dst_x[31], in_data.dst_x})
                 - $signed({in_data.src_x[31], in_data.src_x});
  assign dy      = $signed({in_data.dst_y[31], in_data.dst_y})
                 - $signed({in_data.src_y[31], in_data.src_y});
  assign adx_nxt = dx[32] ? 32'(-dx) : dx[31:0];
  assign ady_nxt = dy[32] ? 32'(-dy) : dy[31:0];

  logic        v1_r, v2_r, v3_r;
  logic        re1_r, re2_r, re3_r;
  load_t       ld1_r, ld2_r, ld3_r;
  logic [31:0] adx_r, ady_r;
  logic        pass_r;
  logic [61:0] sqx_r, sqy_r, cutsq_r;
  logic [62:0] d2;
  logic        inr_nxt, inr3_r;
  logic [61:0] d2_r;

  assign d2      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign inr_nxt = pass_r && (d2 != '0) && (d2 < {1'b0, cutsq_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    adx_r   <= adx_nxt;
    ady_r   <= ady_nxt;
    ld1_r   <= '{infected: in_data.infected_load, carcass: in_data.carcass_load};
    re1_r   <= in_data.row_end_in;
    // hold the pass flag so pairs with either axis at or beyond the cutoff fail the range check
    pass_r  <= (adx_r < {1'b0, cutoff_r}) && (ady_r < {1'b0, cutoff_r});
    sqx_r   <= adx_r[RB-1:0] * adx_r[RB-1:0];
    sqy_r   <= ady_r[RB-1:0] * ady_r[RB-1:0];
    cutsq_r <= cutoff_r * cutoff_r;
    ld2_r   <= ld1_r;
    re2_r   <= re1_r;
    d2_r    <= d2[61:0];
    inr3_r  <= inr_nxt;
    ld3_r   <= ld2_r;
    re3_r   <= re2_r;
  end

  // ---------------- square root ----------------
  logic [RB-1:0] distance;

  pdf_sqrt u_sqrt (
    .clk  (clk),
    .rad  (d2_r),
    .root (distance)
  );

  // ---------------- side lines: valid/flags and loads ----------------
  side_t side_r [LINE];
  load_t lds_r  [SQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LINE; k++) side_r[k].valid <= 1'b0;
    end else begin
      side_r[0].valid <= v3_r;
      for (int k = 1; k < LINE; k++) side_r[k].valid <= side_r[k-1].valid;
    end
    side_r[0].in_range <= inr3_r;
    side_r[0].row_end  <= re3_r;
    for (int k = 1; k < LINE; k++) begin
      side_r[k].in_range <= side_r[k-1].in_range;
      side_r[k].row_end  <= side_r[k-1].row_end;
    end
    lds_r[0] <= ld3_r;
    for (int k = 1; k < SQ; k++) lds_r[k] <= lds_r[k-1];
  end

  // ---------------- kernels ----------------
  pdf_pkg::pdf_term_t live_term, carc_term;

  pdf_kernel #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_live (
    .clk       (clk),
    .distance  (distance),
    .load      (lds_r[SQ-1].infected),
    .intercept (intercept_r),
    .slope     (live_slope_r),
    .weight    (live_weight_r),
    .term      (live_term)
  );

  pdf_kernel #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_carc (
    .clk       (clk),
    .distance  (distance),
    .load      (lds_r[SQ-1].carcass),
    .intercept (intercept_r),
    .slope     (carc_slope_r),
    .weight    (carc_weight_r),
    .term      (carc_term)
  );

  // ---------------- sum, clip, output register ----------------
  logic signed [52:0] sum;
  logic signed [52:0] clip_sum;
  logic               clipped;
  logic               out_valid_r;
  pdf_pkg::pdf_out_t  out_data_r;

  assign sum = {live_term.value[51], live_term.value}
             + {carc_term.value[51], carc_term.value};

  always_comb begin
    clipped  = 1'b0;
    clip_sum = sum;
    if (sum > pdf_pkg::OUT_MAX) begin
      clip_sum = pdf_pkg::OUT_MAX;
      clipped  = 1'b1;
    end else if (sum < pdf_pkg::OUT_MIN) begin
      clip_sum = pdf_pkg::OUT_MIN;
      clipped  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_r[LINE-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    // zero the force and the saturated flag for pairs outside the cutoff
    out_data_r.force_res <= side_r[LINE-1].in_range ? clip_sum[47:0] : '0;
    out_data_r.in_range  <= side_r[LINE-1].in_range;
    out_data_r.saturated <= side_r[LINE-1].in_range
                          && (live_term.capped || carc_term.capped || clipped);
    out_data_r.row_end   <= side_r[LINE-1].row_end;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without a transaction taken PIPE_LAT cycles earlier");

  a_sat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.in_range)
    else $error("saturated set on an out-of-range pair");

  a_zero_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |-> out_data.force_res == '0)
    else $error("nonzero force on an out-of-range pair");

endmodule

FILE: hw/rtl/pdf_sqrt.sv
// Pipelined digit-by-digit integer square root of the squared distance.
`timescale 1ns / 1ps
module pdf_sqrt (
  input  logic                           clk,
  input  logic [2*pdf_pkg::SQRT_BITS-1:0] rad,
  output logic [pdf_pkg::SQRT_BITS-1:0]  root
);

  localparam int RB = pdf_pkg::SQRT_BITS;
  localparam int NS = pdf_pkg::SQRT_STAGES;
  localparam int PS = pdf_pkg::SQRT_PER_STAGE;

  logic [RB+2:0]   rem_r  [NS];
  logic [RB-1:0]   root_r [NS];
  logic [2*RB-1:0] rad_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RB+2:0]   rem_in;
    logic [RB-1:0]   root_in;
    logic [2*RB-1:0] rad_in;
    logic [RB+2:0]   rem_nxt;
    logic [RB-1:0]   root_nxt;
    logic [2*RB-1:0] rad_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign rad_in  = rad_r[s-1];
    end

    always_comb begin
      logic [RB+2:0] r2;
      logic [RB+2:0] trial;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      rad_nxt  = rad_in;
      for (int m = 0; m < PS; m++) begin
        if (s * PS + m < RB) begin
          r2    = {rem_nxt[RB:0], rad_nxt[2*RB-1 -: 2]};
          trial = {1'b0, root_nxt, 2'b01};
          if (r2 >= trial) begin
            rem_nxt  = r2 - trial;
            root_nxt = {root_nxt[RB-2:0], 1'b1};
          end else begin
            rem_nxt  = r2;
            root_nxt = {root_nxt[RB-2:0], 1'b0};
          end
          rad_nxt = {rad_nxt[2*RB-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      rad_r[s]  <= rad_nxt;
    end
  end

  assign root = root_r[NS-1];

endmodule

FILE: hw/rtl/pdf_kernel.sv
// One distance-decay kernel term: exponent, Horner 2^f series, load and weight scaling.
`timescale 1ns / 1ps
module pdf_kernel #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic [30:0]         distance,
  input  logic [15:0]         load,
  input  logic [31:0]         intercept,
  input  logic [31:0]         slope,
  input  logic [31:0]         weight,
  output pdf_pkg::pdf_term_t  term
);

  localparam int HT      = pdf_pkg::HORNER_TERMS;
  localparam int LD_LINE = 4 + 3 * HT;
  localparam int N_LINE  = 1 + 3 * HT;

  // Side lines: load from the first stage, integer exponent from the fourth
  logic [15:0]       ld_r [LD_LINE];
  logic signed [8:0] n_r  [N_LINE];

  // Exponent front end
  logic signed [63:0] pk_r;
  logic signed [63:0] xs;
  logic signed [31:0] x_nxt, x_r;
  logic signed [63:0] ym_r;
  logic signed [63:0] yq;
  logic signed [8:0]  n_nxt;
  logic [59:0]        tm_r;

  assign xs = $signed({{32{intercept[31]}}, intercept}) + (pk_r >>> COORD_FRAC_BITS);

  always_comb begin
    if (xs > pdf_pkg::EXP_CLAMP) begin
      x_nxt = 32'(pdf_pkg::EXP_CLAMP);
    end else if (xs < -pdf_pkg::EXP_CLAMP) begin
      x_nxt = 32'(-pdf_pkg::EXP_CLAMP);
    end else begin
      x_nxt = 32'(xs);
    end
  end

  assign yq    = ym_r >>> 24;
  assign n_nxt = 9'(yq >>> 30);

  always_ff @(posedge clk) begin
    pk_r <= $signed(slope) * $signed({1'b0, distance});
    x_r  <= x_nxt;
    ym_r <= x_r * $signed({1'b0, pdf_pkg::LOG2E_Q30});
    tm_r <= yq[29:0] * pdf_pkg::LN2_Q30;
    ld_r[0] <= load;
    n_r[0]  <= n_nxt;
    for (int k = 1; k < LD_LINE; k++) ld_r[k] <= ld_r[k-1];
    for (int k = 1; k < N_LINE; k++) n_r[k] <= n_r[k-1];
  end

  // Horner chain: s = 1 + (t*s)/i for i from HT down to 1
  logic [61:0] ha_prod_r [HT];
  logic [29:0] ha_t_r    [HT];
  logic [64:0] hb_qm_r   [HT];
  logic [31:0] hb_u_r    [HT];
  logic [29:0] hb_t_r    [HT];
  logic [31:0] hs_r      [HT];
  logic [29:0] hc_t_r    [HT];

  for (genvar j = 0; j < HT; j++) begin : g_horner
    localparam int DIV = HT - j;
    logic [29:0] t_in;
    logic [31:0] s_in;
    logic [31:0] q0, rem, q;

    if (j == 0) begin : g_first
      assign t_in = tm_r[59:30];
      assign s_in = pdf_pkg::ONE_Q30;
    end else begin : g_next
      assign t_in = hc_t_r[j-1];
      assign s_in = hs_r[j-1];
    end

    assign q0  = hb_qm_r[j][63:32];
    assign rem = hb_u_r[j] - q0 * 32'(DIV);
    assign q   = (rem >= 32'(DIV)) ? q0 + 32'd1 : q0;

    always_ff @(posedge clk) begin
      ha_prod_r[j] <= t_in * s_in;
      ha_t_r[j]    <= t_in;
      hb_qm_r[j]   <= ha_prod_r[j][61:30] * pdf_pkg::HORNER_RECIP[DIV];
      hb_u_r[j]    <= ha_prod_r[j][61:30];
      hb_t_r[j]    <= ha_t_r[j];
      hs_r[j]      <= pdf_pkg::ONE_Q30 + q;
      hc_t_r[j]    <= hb_t_r[j];
    end
  end

  // Scale back end: |b| * load * m * 2^(n-38), capped at 2^50
  logic [47:0]       q_r;
  logic signed [8:0] n1_r, n2_r, n3_r;
  logic [31:0]       bw;
  logic [47:0]       pa_r;
  logic [63:0]       pb_r;
  logic [79:0]       p_r;
  logic signed [9:0] sh, cs;
  logic              cap;
  logic [79:0]       shifted;
  logic [50:0]       mag;

  assign bw = weight[31] ? 32'(-weight) : weight;
  assign sh = 10'(pdf_pkg::SCALE_SHIFT) - 10'(n3_r);
  assign cs = sh + 10'(pdf_pkg::CAP_BITS);

  always_comb begin
    if (cs < 0) begin
      cap = (p_r != '0);
    end else begin
      cap = ((p_r >> cs[7:0]) != '0);
    end
    if (sh >= 0) begin
      shifted = p_r >> sh[7:0];
    end else begin
      shifted = p_r << 7'(-sh);
    end
    mag = cap ? (51'd1 << pdf_pkg::CAP_BITS) : shifted[50:0];
  end

  always_ff @(posedge clk) begin
    q_r  <= ld_r[LD_LINE-1] * hs_r[HT-1];
    n1_r <= n_r[N_LINE-1];
    pa_r <= bw * q_r[47:32];
    pb_r <= bw * q_r[31:0];
    n2_r <= n1_r;
    p_r  <= {pa_r, 32'd0} + {16'd0, pb_r};
    n3_r <= n2_r;
    term.value  <= weight[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    term.capped <= cap;
  end

endmodule
